// ----- hw/rtl/aes_cfb_byte_and_bit_stream_macros.svh -----
// assertion macros for the aes cfb stream engine
// no dependencies; included by files that carry assertions
`ifndef AES_CFB_BYTE_AND_BIT_STREAM_MACROS_SVH
`define AES_CFB_BYTE_AND_BIT_STREAM_MACROS_SVH
`ifndef SYNTHESIS
`define ACB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assert");
`define ACB_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("never");
`else
`define ACB_ASSERT(label, clk, rst_n, prop)
`define ACB_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- hw/rtl/acb_pkg.sv -----
// package for the aes cfb stream engine: payload types, states, sbox and helpers
// no dependencies
package acb_pkg;

  localparam int unsigned RkDepth = 60;
  localparam int unsigned RkAw    = 6;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDw   = 64;

  localparam logic [CfgIdxW-1:0] RegKey0    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegKey1    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKey2    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKey3    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeySize = 3'd4;
  localparam logic [CfgIdxW-1:0] RegIvHigh  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegIvLow   = 3'd6;
  localparam logic [CfgIdxW-1:0] RegMode    = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       end_of_call;
  } acb_in_t;

  typedef struct packed {
    logic [7:0] result_byte;
    logic       end_marker;
  } acb_out_t;

  typedef enum logic [3:0] {
    StIdle, StKeyLoad, StKeyRd, StKeyWr, StRkRd, StRound0, StRound, StBit, StOut
  } acb_state_e;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // one aes round without the key add; byte 0 in the top bits
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] all;
    logic [127:0] r;
    for (int k = 0; k < 16; k++) b[k] = s[127-8*k -: 8];
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) t[4*c+j] = sbox(b[4*((c+j)%4)+j]);
    end
    for (int c = 0; c < 4; c++) begin
      all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
      for (int j = 0; j < 4; j++) begin
        r[127-8*(4*c+j) -: 8] = last ? t[4*c+j]
          : t[4*c+j] ^ all ^ xtime(t[4*c+j] ^ t[4*c+(j+1)%4]);
      end
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/acb_ram.sv -----
// generic single-port write, single-port read ram with registered read
// no dependencies
module acb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 60,
  parameter int unsigned Aw    = 6
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/aes_cfb_byte_and_bit_stream.sv -----
// AES CFB8/CFB1 byte stream engine. One encryption issues the first round key read, reads
// one round key word per cycle and xors it into one column, and applies an aes round after
// each four columns but the last; then the keystream is consumed. CFB8 runs one encryption
// per byte and CFB1 runs eight. The output register is then loaded and the engine returns
// to idle, where the next transaction is taken at the earliest. The single round key ram
// read port, read one 32-bit word per cycle, paces each encryption. A restart transaction
// first expands the key into the ram: the raw key words at one per cycle, then each derived
// word through a read state and a write state. A new transaction is held off while a
// finished result waits under stall; one transaction is in flight.
// depends on acb_pkg, acb_ram and the macros header
`include "aes_cfb_byte_and_bit_stream_macros.svh"
module aes_cfb_byte_and_bit_stream import acb_pkg::*; #(
  parameter int unsigned RkWords = RkDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  acb_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output acb_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDw-1:0]   cfg_wdata_i
);

  // configuration registers
  logic [63:0] key_q [4];
  logic [1:0]  ksize_q, mode_q;
  logic [63:0] ivh_q, ivl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      ksize_q <= '0; mode_q <= '0; ivh_q <= '0; ivl_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegKey0:    key_q[0] <= cfg_wdata_i;
        RegKey1:    key_q[1] <= cfg_wdata_i;
        RegKey2:    key_q[2] <= cfg_wdata_i;
        RegKey3:    key_q[3] <= cfg_wdata_i;
        RegKeySize: ksize_q <= cfg_wdata_i[1:0];
        RegIvHigh:  ivh_q <= cfg_wdata_i;
        RegIvLow:   ivl_q <= cfg_wdata_i;
        RegMode:    mode_q <= cfg_wdata_i[1:0];
        default:    ;
      endcase
    end
  end

  acb_state_e  st_q, st_d;
  logic [127:0] fb_q, fb_d, s_q, s_d;
  logic [7:0]  t_q, t_d, rcon_q, rcon_d;
  logic        eoc_q, eoc_d;
  logic [3:0]  nr_q, nr_d, rnd_q, rnd_d;
  logic [3:0]  nk_q, nk_d, kc_q, kc_d;
  logic [1:0]  col_q, col_d;
  logic [2:0]  bit_q, bit_d;
  logic [RkAw-1:0] wi_q, wi_d;
  logic [31:0] prev_q, prev_d;
  logic        ov_q, ov_d;
  acb_out_t    od_q, od_d;

  logic            rk_we;
  logic [RkAw-1:0] rk_waddr, rk_raddr;
  logic [31:0]     rk_wdata, rk_rdata;

  acb_ram #(.Width(32), .Depth(RkWords), .Aw(RkAw)) u_rk (
    .clk_i, .we_i(rk_we), .waddr_i(rk_waddr), .wdata_i(rk_wdata),
    .raddr_i(rk_raddr), .rdata_o(rk_rdata)
  );

  logic [RkAw-1:0] total;
  logic [31:0]     kw, tx, ksrc;
  logic [RkAw-1:0] col_addr;
  logic [7:0]      ks_bit, ks_byte, cb;
  logic [127:0]    colx;
  logic [1:0]      ksel;
  logic            accept;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle) || (ov_q && out_stall_i);
  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;
  assign col_addr = RkAw'({rnd_q, 2'b00} + {4'd0, col_q});
  assign total    = RkAw'({nr_q + 4'd1, 2'b00});

  // key word source for the first nk words
  assign ksrc = wi_q[0] ? key_q[wi_q[2:1]][31:0] : key_q[wi_q[2:1]][63:32];

  always_comb begin
    st_d = st_q; fb_d = fb_q; s_d = s_q; t_d = t_q; rcon_d = rcon_q;
    eoc_d = eoc_q; nr_d = nr_q; rnd_d = rnd_q; nk_d = nk_q; kc_d = kc_q;
    col_d = col_q; bit_d = bit_q; wi_d = wi_q; prev_d = prev_q;
    ov_d = ov_q; od_d = od_q;
    rk_we = 1'b0; rk_waddr = wi_q; rk_wdata = '0; rk_raddr = col_addr;
    kw = '0; tx = prev_q; colx = '0; ks_bit = '0; ks_byte = '0; cb = '0; ksel = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (st_q)
      StIdle: begin
        if (accept) begin
          t_d = in_data_i.data_byte; eoc_d = in_data_i.end_of_call;
          rnd_d = '0; col_d = '0; bit_d = '0;
          if (in_data_i.restart) begin
            fb_d = {ivh_q, ivl_q};
            ksel = (ksize_q == 2'd3) ? 2'd2 : ksize_q;
            nk_d = 4'd4 + {1'b0, ksel, 1'b0};
            nr_d = 4'd10 + {1'b0, ksel, 1'b0};
            wi_d = '0; kc_d = '0; rcon_d = 8'h01;
            st_d = StKeyLoad;
          end else begin
            s_d = fb_q;
            st_d = StRkRd;
          end
        end
      end
      // copy the raw key words
      StKeyLoad: begin
        rk_we = 1'b1; rk_wdata = ksrc; prev_d = ksrc;
        wi_d = wi_q + 1'b1;
        if (RkAw'(nk_q) == wi_q + 1'b1) begin
          st_d = StKeyRd; kc_d = '0;
        end
      end
      // read word i - nk
      StKeyRd: begin
        rk_raddr = wi_q - RkAw'(nk_q);
        st_d = StKeyWr;
      end
      StKeyWr: begin
        if (kc_q == 4'd0) begin
          tx = sub_word({prev_q[23:0], prev_q[31:24]}) ^ {rcon_q, 24'd0};
          rcon_d = xtime(rcon_q);
        end else if (nk_q > 4'd6 && kc_q == 4'd4) begin
          tx = sub_word(prev_q);
        end
        kw = rk_rdata ^ tx;
        rk_we = 1'b1; rk_wdata = kw; prev_d = kw;
        wi_d = wi_q + 1'b1;
        kc_d = (kc_q + 4'd1 == nk_q) ? 4'd0 : kc_q + 4'd1;
        if (wi_q + 1'b1 == total) begin
          st_d = StRkRd; s_d = fb_q;
        end else begin
          st_d = StKeyRd;
        end
      end
      // issue round key read of column 0
      StRkRd: begin
        st_d = StRound;
      end
      // xor one column per cycle, round after the fourth unless it is the last round key
      StRound: begin
        colx = s_q;
        colx[127-32*col_q -: 32] = s_q[127-32*col_q -: 32] ^ rk_rdata;
        s_d = colx;
        col_d = col_q + 2'd1;
        rk_raddr = RkAw'({rnd_q, 2'b00} + {4'd0, col_q} + 1'b1);
        if (col_q == 2'd3) begin
          if (rnd_q == nr_q) begin
            st_d = StBit;
          end else begin
            s_d = aes_round(colx, rnd_q + 4'd1 == nr_q);
            rnd_d = rnd_q + 4'd1;
          end
        end
      end
      // consume keystream
      StBit: begin
        ks_byte = s_q[127:120];
        if (!mode_q[1]) begin
          cb = mode_q[0] ? t_q : (t_q ^ ks_byte);
          t_d = t_q ^ ks_byte;
          fb_d = {fb_q[119:0], cb};
          st_d = StOut;
        end else begin
          ks_bit = {ks_byte[7], 7'd0} >> bit_q;
          cb = mode_q[0] ? t_q : (t_q ^ ks_bit);
          t_d = t_q ^ ks_bit;
          fb_d = {fb_q[126:0], cb[3'd7 - bit_q]};
          bit_d = bit_q + 3'd1;
          if (bit_q == 3'd7) begin
            st_d = StOut;
          end else begin
            s_d = {fb_q[126:0], cb[3'd7 - bit_q]};
            rnd_d = '0; col_d = '0;
            st_d = StRkRd;
          end
          rk_raddr = '0;
        end
      end
      StOut: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1; od_d = '{result_byte: t_q, end_marker: eoc_q};
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
    if (st_d == StRkRd) rk_raddr = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; fb_q <= '0; nr_q <= 4'd10; ov_q <= 1'b0;
      nk_q <= 4'd4; rnd_q <= '0; col_q <= '0; bit_q <= '0; kc_q <= '0; wi_q <= '0;
    end else begin
      st_q <= st_d; fb_q <= fb_d; nr_q <= nr_d; ov_q <= ov_d;
      nk_q <= nk_d; rnd_q <= rnd_d; col_q <= col_d; bit_q <= bit_d; kc_q <= kc_d;
      wi_q <= wi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d; t_q <= t_d; rcon_q <= rcon_d; eoc_q <= eoc_d; prev_q <= prev_d;
    od_q <= od_d;
  end

  `ACB_ASSERT(a_out_hold, clk_i, rst_ni, (ov_q && out_stall_i) |=> (ov_q && $stable(od_q)))
  `ACB_ASSERT(a_one_flight, clk_i, rst_ni, accept |=> (st_q != StIdle))
  `ACB_ASSERT_NEVER(a_rnd_range, clk_i, rst_ni, rnd_q > nr_q)
  `ACB_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(ov_q) |-> ($past(st_q) == StOut))

endmodule

// ----- bench/testbench.sv -----
// self-checking bench for the aes cfb8/cfb1 byte stream engine
// depends on acb_pkg and the aes_cfb_byte_and_bit_stream rtl
module testbench import acb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 700;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  acb_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  acb_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDw-1:0] cfg_wdata_i = '0;

  aes_cfb_byte_and_bit_stream u_top (.*);

  always #6 clk_i = ~clk_i;

  // cipher model state
  logic [7:0] sub_tbl [256];
  logic [63:0] key_reg [4];
  logic [1:0] key_size_reg;
  logic [63:0] iv_hi_reg, iv_lo_reg;
  logic [1:0] mode_reg;
  logic [127:0] shift_reg;
  logic [31:0] sched [60];
  int unsigned round_cnt;

  acb_out_t expected_q [$];
  int unsigned errors, items_sent, results_seen, cycles;
  int unsigned send_idle_pct, stall_pct, hold_left;

  function automatic logic [7:0] gf_dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = gf_dbl(a);
    end
    return p;
  endfunction

  // sbox built from field inverse and affine map
  task automatic build_sbox();
    logic [7:0] inv, x;
    for (int a = 0; a < 256; a++) begin
      inv = 8'h00;
      for (int b = 1; b < 256; b++) if (gf_mul(8'(a), 8'(b)) == 8'h01) inv = 8'(b);
      x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
        ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sub_tbl[a] = x;
    end
  endtask

  function automatic logic [31:0] sub_w(input logic [31:0] w);
    return {sub_tbl[w[31:24]], sub_tbl[w[23:16]], sub_tbl[w[15:8]], sub_tbl[w[7:0]]};
  endfunction

  function automatic void expand_schedule();
    int unsigned nk, total;
    logic [7:0] rc;
    logic [31:0] t;
    rc = 8'h01;
    nk = (key_size_reg == 2'd0) ? 4 : (key_size_reg == 2'd1) ? 6 : 8;
    round_cnt = nk + 6;
    total = 4 * (round_cnt + 1);
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? key_reg[i >> 1][31:0] : key_reg[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = sched[i - 1];
      if (i % nk == 0) begin
        t = sub_w({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_w(t);
      end
      sched[i] = sched[i - nk] ^ t;
    end
  endfunction

  // first byte of the block cipher output for the current shift register
  function automatic logic [7:0] keystream_byte();
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] all;
    for (int k = 0; k < 16; k++) s[k] = shift_reg[127 - 8 * k -: 8];
    for (int r = 0; r <= round_cnt; r++) begin
      if (r > 0) begin
        for (int c = 0; c < 4; c++)
          for (int j = 0; j < 4; j++) t[4 * c + j] = sub_tbl[s[4 * ((c + j) % 4) + j]];
        for (int c = 0; c < 4; c++) begin
          all = t[4 * c] ^ t[4 * c + 1] ^ t[4 * c + 2] ^ t[4 * c + 3];
          for (int j = 0; j < 4; j++)
            s[4 * c + j] = (r == round_cnt) ? t[4 * c + j] :
              t[4 * c + j] ^ all ^ gf_dbl(t[4 * c + j] ^ t[4 * c + (j + 1) % 4]);
        end
      end
      for (int c = 0; c < 4; c++)
        for (int j = 0; j < 4; j++)
          s[4 * c + j] ^= sched[(r * 4 + c) % 60][31 - 8 * j -: 8];
    end
    return s[0];
  endfunction

  // predicted output byte for one transaction, advances the shift register
  function automatic acb_out_t cfb_predict(input acb_in_t item);
    acb_out_t res;
    logic [7:0] d, ks;
    logic cbit;
    d = item.data_byte;
    if (item.restart) begin
      shift_reg = {iv_hi_reg, iv_lo_reg};
      expand_schedule();
    end
    if (!mode_reg[1]) begin
      ks = keystream_byte();
      shift_reg = {shift_reg[119:0], mode_reg[0] ? d : d ^ ks};
      d = d ^ ks;
    end else begin
      for (int b = 0; b < 8; b++) begin
        ks = keystream_byte();
        if (mode_reg[0]) begin
          cbit = d[7 - b];
          d[7 - b] = d[7 - b] ^ ks[7];
        end else begin
          d[7 - b] = d[7 - b] ^ ks[7];
          cbit = d[7 - b];
        end
        shift_reg = {shift_reg[126:0], cbit};
      end
    end
    res.result_byte = d;
    res.end_marker = item.end_of_call;
    return res;
  endfunction

  // register write, only while idle
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      RegKey0: key_reg[0] = val;
      RegKey1: key_reg[1] = val;
      RegKey2: key_reg[2] = val;
      RegKey3: key_reg[3] = val;
      RegKeySize: key_size_reg = val[1:0];
      RegIvHigh: iv_hi_reg = val;
      RegIvLow: iv_lo_reg = val;
      RegMode: mode_reg = val[1:0];
      default: ;
    endcase
  endtask

  task automatic setup_cipher(input logic [255:0] key, input logic [1:0] ksz,
                              input logic [127:0] iv, input logic [1:0] mode);
    write_reg(RegKey0, key[255:192]);
    write_reg(RegKey1, key[191:128]);
    write_reg(RegKey2, key[127:64]);
    write_reg(RegKey3, key[63:0]);
    write_reg(RegKeySize, {62'h0, ksz});
    write_reg(RegIvHigh, iv[127:64]);
    write_reg(RegIvLow, iv[63:0]);
    write_reg(RegMode, {62'h0, mode});
  endtask

  // send one transaction; called and returns just after a falling edge
  task automatic send_byte(input logic [7:0] d, input logic rs, input logic eoc);
    acb_in_t item;
    logic accepted;
    item.data_byte = d;
    item.restart = rs;
    item.end_of_call = eoc;
    expected_q.push_back(cfb_predict(item));
    in_data_i = item;
    in_valid_i = 1'b1;
    forever begin
      #1;
      accepted = !in_stall_o;
      @(posedge clk_i);
      @(negedge clk_i);
      if (accepted) break;
    end
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(8, 1)) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_idling(input int unsigned s, input int unsigned r);
    send_idle_pct = s;
    stall_pct = r;
  endtask

  function automatic logic [255:0] rand_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [127:0] rand_iv();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // receiver stall, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    acb_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: %h", out_data_o);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_data_o.result_byte !== want.result_byte) begin
          $error("result_byte expected %h actual %h", want.result_byte,
                 out_data_o.result_byte);
          errors++;
        end
        if (out_data_o.end_marker !== want.end_marker) begin
          $error("end_marker expected %b actual %b", want.end_marker,
                 out_data_o.end_marker);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // extremes of data and flags under every key size and mode
  task automatic test_directed();
    set_idling(0, 0);
    setup_cipher('0, 2'd0, '0, 2'd0);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hff, 1'b0, 1'b1);
    drain();
    setup_cipher('1, 2'd3, '1, 2'd3);
    send_byte(8'hff, 1'b1, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    drain();
    for (int ks = 0; ks < 4; ks++) begin
      for (int m = 0; m < 4; m++) begin
        setup_cipher(rand_key(), ks[1:0], rand_iv(), m[1:0]);
        send_byte(8'h80, 1'b1, 1'b0);
        drain();
      end
    end
    // mode change without restart, then a key change that waits for restart
    write_reg(RegMode, 64'd1);
    send_byte(8'h5a, 1'b0, 1'b1);
    drain();
    write_reg(RegKey0, '1);
    write_reg(RegIvLow, '1);
    send_byte(8'ha5, 1'b0, 1'b0);
    send_byte(8'h3c, 1'b1, 1'b1);
    drain();
  endtask

  // random streams over random settings and idling phases
  task automatic test_random_streams(input int unsigned n_items);
    int unsigned sent;
    logic [1:0] m;
    sent = 0;
    while (sent < n_items) begin
      m = ($urandom_range(3) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1));
      setup_cipher(rand_key(), 2'($urandom_range(3)), rand_iv(), m);
      send_byte(8'($urandom), 1'b1, 1'($urandom_range(3) == 0));
      sent++;
      for (int i = 0; i < 40 && sent < n_items; i++) begin
        send_byte(8'($urandom), ($urandom_range(29) == 0), ($urandom_range(4) == 0));
        sent++;
      end
      drain();
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_idling(0, 0);
    setup_cipher(rand_key(), 2'd0, rand_iv(), 2'd0);
    hold_left = 400;
    for (int i = 0; i < 12; i++) send_byte(8'($urandom), (i == 0), 1'b0);
    drain();
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    cycles = 0;
    hold_left = 0;
    set_idling(0, 0);
    build_sbox();
    key_reg = '{default: '0};
    key_size_reg = '0;
    iv_hi_reg = '0;
    iv_lo_reg = '0;
    mode_reg = '0;
    shift_reg = '0;
    sched = '{default: '0};
    round_cnt = 10;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    set_idling(0, 0);
    test_random_streams(250);
    set_idling(85, 0);
    test_random_streams(200);
    set_idling(0, 85);
    test_random_streams(200);
    set_idling(20, 20);
    test_random_streams(250);
    test_backpressure();

    $display("ran %0d bytes, %0d results, cfb8 and cfb1 both ways, key sizes 128..256",
             items_sent, results_seen);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/acb_pkg.sv
hw/rtl/acb_ram.sv
hw/rtl/aes_cfb_byte_and_bit_stream.sv
bench/testbench.sv
